// File: rtl/qec_pkg.sv
// shared types and constants of the quadrature encoder counter
package qec_pkg;

    localparam int CfgIdxWidth = 2;
    localparam int PosWidth    = 17;
    localparam int AbsWidth    = 16;
    localparam int TotalWidth  = 32;
    localparam int AngleWidth  = 25;
    localparam int ProdWidth   = 48;
    localparam int HalfWidth   = 24;
    localparam int PartWidth   = 49;
    localparam int SumWidth    = 50;
    localparam int MagWidth    = 42;
    localparam int InTdataW    = 8;
    localparam int OutTdataW   = 112;

    localparam logic [CfgIdxWidth-1:0] CFG_COUNTS_PER_REV = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_REVERSE_DIR    = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_RECIP_COUNTS   = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_ANGLE_UNIT     = 2'd3;

    localparam logic [15:0]           RST_COUNTS_PER_REV = 16'd1024;
    localparam logic [31:0]           RST_RECIP_COUNTS   = 32'd4194304;
    localparam logic [AngleWidth-1:0] FULL_DEG           = 25'd23592960;
    localparam logic [AngleWidth-1:0] FULL_RAD           = 25'd411775;
    localparam logic [AngleWidth-1:0] ANGLE_MAX          = 25'h1FFFFFF;

    typedef struct packed {
        logic [15:0] counts_per_rev;
        logic        reverse_direction;
        logic [31:0] recip_counts;
        logic        angle_unit;
    } t_cfg;

    typedef struct packed {
        logic [PosWidth-1:0]   position;
        logic [TotalWidth-1:0] tick_total;
        logic [TotalWidth-1:0] revolution_total;
        logic                  counted;
        logic                  neg;
    } t_side;

endpackage

// File: rtl/qec_count.sv
// edge detection, position and total counters, first pipeline stage
module qec_count
    import qec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_level_a,
    input  logic                i_level_b,
    output logic                o_valid,
    input  logic                i_ready,
    output t_side               o_side,
    output logic [AbsWidth-1:0] o_abs
);

    logic                   r_prev_a;
    logic [PosWidth-1:0]    r_pos;
    logic [COUNT_WIDTH-1:0] r_tick;
    logic [COUNT_WIDTH-1:0] r_rev;
    logic                   r_valid;
    t_side                  r_side;
    logic [AbsWidth-1:0]    r_abs;

    logic                   n_prev_a;
    logic [PosWidth-1:0]    n_pos;
    logic [COUNT_WIDTH-1:0] n_tick;
    logic [COUNT_WIDTH-1:0] n_rev;
    logic                   n_edge;
    logic                   fwd;
    logic [PosWidth:0]      pos_ext;
    logic [PosWidth:0]      lim_ext;
    logic [PosWidth:0]      neg_lim;
    logic [PosWidth:0]      pos_inc;
    logic [PosWidth:0]      pos_dec;
    logic [PosWidth-1:0]    pos_mag;
    logic [TotalWidth-1:0]  tick_w;
    logic [TotalWidth-1:0]  rev_w;
    logic                   accept;

    localparam logic [COUNT_WIDTH-1:0] CntOne = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        pos_ext  = {r_pos[PosWidth-1], r_pos};
        lim_ext  = {2'b00, i_cfg.counts_per_rev};
        neg_lim  = '0 - lim_ext;
        pos_inc  = pos_ext + {{PosWidth{1'b0}}, 1'b1};
        pos_dec  = pos_ext - {{PosWidth{1'b0}}, 1'b1};
        n_edge   = !r_prev_a && i_level_a;
        fwd      = (i_level_a == i_level_b) ^ i_cfg.reverse_direction;
        n_prev_a = i_level_a;
        n_pos    = r_pos;
        n_tick   = r_tick;
        n_rev    = r_rev;
        if (n_edge) begin
            if (fwd) begin
                n_tick = r_tick + CntOne;
                if ($signed(pos_inc) > $signed(lim_ext)) begin
                    n_pos = '0;
                    n_rev = r_rev + CntOne;
                end else begin
                    n_pos = pos_inc[PosWidth-1:0];
                end
            end else begin
                n_tick = r_tick - CntOne;
                if ($signed(pos_dec) < $signed(neg_lim)) begin
                    n_pos = '0;
                    n_rev = r_rev - CntOne;
                end else begin
                    n_pos = pos_dec[PosWidth-1:0];
                end
            end
        end
        pos_mag = n_pos[PosWidth-1] ? ('0 - n_pos) : n_pos;
    end

    // totals are sign-extended or cut to the 32-bit output fields
    generate
        if (COUNT_WIDTH >= TotalWidth) begin : g_wide
            assign tick_w = n_tick[TotalWidth-1:0];
            assign rev_w  = n_rev[TotalWidth-1:0];
        end else begin : g_narrow
            assign tick_w = {{(TotalWidth-COUNT_WIDTH){n_tick[COUNT_WIDTH-1]}}, n_tick};
            assign rev_w  = {{(TotalWidth-COUNT_WIDTH){n_rev[COUNT_WIDTH-1]}}, n_rev};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
            r_pos    <= '0;
            r_tick   <= '0;
            r_rev    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_a <= n_prev_a;
                r_pos    <= n_pos;
                r_tick   <= n_tick;
                r_rev    <= n_rev;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_side.position         <= n_pos;
            r_side.tick_total       <= tick_w;
            r_side.revolution_total <= rev_w;
            r_side.counted          <= n_edge;
            r_side.neg              <= n_pos[PosWidth-1];
            r_abs                   <= pos_mag[AbsWidth-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_abs   = r_abs;

endmodule

// File: rtl/qec_angle.sv
// angle scaling pipeline and output register
module qec_angle
    import qec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_side                 i_side,
    input  logic [AbsWidth-1:0]   i_abs,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_side                 o_side,
    output logic [AngleWidth-1:0] o_angle
);

    logic                  r_v2;
    logic                  r_v3;
    logic                  r_vo;
    t_side                 r_side2;
    t_side                 r_side3;
    t_side                 r_side_o;
    logic [ProdWidth-1:0]  r_m;
    logic [PartWidth-1:0]  r_hi;
    logic [PartWidth-1:0]  r_lo;
    logic [AngleWidth-1:0] r_angle;

    logic                  rdy2;
    logic                  rdy3;
    logic                  rdy_o;
    logic [AngleWidth-1:0] full;
    logic [ProdWidth-1:0]  n_m;
    logic [PartWidth-1:0]  n_hi;
    logic [PartWidth-1:0]  n_lo;
    logic [SumWidth-1:0]   sum;
    logic [MagWidth-1:0]   mag;
    logic [MagWidth-1:0]   full_ext;
    logic [MagWidth-1:0]   ang;
    logic [AngleWidth-1:0] n_angle;

    assign rdy_o   = !r_vo || i_ready;
    assign rdy3    = !r_v3 || rdy_o;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    assign full = i_cfg.angle_unit ? FULL_RAD : FULL_DEG;
    assign n_m  = ProdWidth'(i_abs) * ProdWidth'(i_cfg.recip_counts);
    assign n_hi = PartWidth'(r_m[ProdWidth-1:HalfWidth]) * PartWidth'(full);
    assign n_lo = PartWidth'(r_m[HalfWidth-1:0]) * PartWidth'(full);

    always_comb begin
        sum      = {1'b0, r_hi} + {{(SumWidth-PartWidth+HalfWidth){1'b0}},
                                   r_lo[PartWidth-1:HalfWidth]};
        mag      = sum[SumWidth-1:8];
        full_ext = {{(MagWidth-AngleWidth){1'b0}}, full};
        if (!r_side3.neg) begin
            ang = mag;
        end else if (i_cfg.recip_counts == '0) begin
            ang = '0;
        end else if (mag >= full_ext) begin
            ang = '0;
        end else begin
            ang = full_ext - mag;
        end
        if (ang[MagWidth-1:AngleWidth] != '0) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = ang[AngleWidth-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_o) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_side2 <= i_side;
            r_m     <= n_m;
        end
        if (rdy3) begin
            r_side3 <= r_side2;
            r_hi    <= n_hi;
            r_lo    <= n_lo;
        end
        if (rdy_o) begin
            r_side_o <= r_side3;
            r_angle  <= n_angle;
        end
    end

    assign o_valid = r_vo;
    assign o_side  = r_side_o;
    assign o_angle = r_angle;

endmodule

// File: rtl/quadrature_encoder_counter_core.sv
// top level of the x1 quadrature encoder counter with wheel angle
//
// s_axis carries one sample of the encoder lines per item, m_axis returns
// one result item per sample: position, tick and revolution totals, the
// wheel angle in unsigned q9.16 and a flag for a counted rising edge of a.
// the cfg port writes counts per revolution, direction swap, reciprocal
// and angle unit; write it only while no item is in flight.
// an item passes four registers before m_axis_tvalid rises: the counter
// stage, the position-times-reciprocal multiply, the two split multiplies
// by the full turn, and the add and clamp into the output register. one
// item is accepted every cycle while m_axis_tready is high.
// reset clears the counters and empties the pipeline; the registers
// return to 1024 counts, forward, reciprocal 4194304, degrees.
// when m_axis_tready is low the four stages fill up and s_axis_tready
// drops only once all of them hold an item.
module quadrature_encoder_counter_core
    import qec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] level_a, [1] level_b
    input  logic [InTdataW-1:0]    s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [16:0] position, [48:17] tick_total, [80:49] revolution_total,
    // [105:81] angle, [106] counted
    output logic [OutTdataW-1:0]   m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_idx,
    input  logic [31:0]            i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  cnt_valid;
    logic                  ang_ready;
    t_side                 cnt_side;
    logic [AbsWidth-1:0]   cnt_abs;
    t_side                 out_side;
    logic [AngleWidth-1:0] out_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.counts_per_rev    <= RST_COUNTS_PER_REV;
            r_cfg.reverse_direction <= 1'b0;
            r_cfg.recip_counts      <= RST_RECIP_COUNTS;
            r_cfg.angle_unit        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COUNTS_PER_REV: r_cfg.counts_per_rev    <= i_cfg_data[15:0];
                CFG_REVERSE_DIR:    r_cfg.reverse_direction <= i_cfg_data[0];
                CFG_RECIP_COUNTS:   r_cfg.recip_counts      <= i_cfg_data;
                CFG_ANGLE_UNIT:     r_cfg.angle_unit        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    qec_count #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_level_a (s_axis_tdata[0]),
        .i_level_b (s_axis_tdata[1]),
        .o_valid   (cnt_valid),
        .i_ready   (ang_ready),
        .o_side    (cnt_side),
        .o_abs     (cnt_abs)
    );

    qec_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (cnt_valid),
        .o_ready (ang_ready),
        .i_side  (cnt_side),
        .i_abs   (cnt_abs),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_side  (out_side),
        .o_angle (out_angle)
    );

    assign m_axis_tdata = {5'b0, out_side.counted, out_angle, out_side.revolution_total,
                           out_side.tick_total, out_side.position};

endmodule

// File: tb/tb_quadrature_encoder_counter_core.sv
// self-checking testbench of the x1 quadrature encoder counter core
module tb_quadrature_encoder_counter_core;
    import qec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 108;
    localparam int SETTLE_WAIT  = 8;

    typedef struct packed {
        logic [4:0]            pad;
        logic                  counted;
        logic [AngleWidth-1:0] angle;
        logic [TotalWidth-1:0] revolutions;
        logic [TotalWidth-1:0] ticks;
        logic [PosWidth-1:0]   position;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CfgIdxWidth-1:0] idx;
        logic [31:0]           data;
        logic                  a;
        logic                  b;
        bit                    typed;
        t_result               want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [InTdataW-1:0]    s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OutTdataW-1:0]   m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] i_cfg_idx = '0;
    logic [31:0]            i_cfg_data = '0;

    quadrature_encoder_counter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // encoder model state and register copies
    logic [15:0]           enc_cpr = RST_COUNTS_PER_REV;
    logic                  enc_reverse = 1'b0;
    logic [31:0]           enc_recip = RST_RECIP_COUNTS;
    logic                  enc_radians = 1'b0;
    logic                  enc_prev_a = 1'b0;
    int                    enc_pos = 0;
    logic [TotalWidth-1:0] enc_ticks = '0;
    logic [TotalWidth-1:0] enc_revs = '0;

    t_result expected_results[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;
    t_row    directed_rows[$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [AngleWidth-1:0] wheel_angle(int pos);
        longint unsigned full;
        longint unsigned mag_pos;
        longint unsigned prod;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned mag;
        longint unsigned res;
        full = enc_radians ? FULL_RAD : FULL_DEG;
        mag_pos = (pos < 0) ? longint'(-pos) : longint'(pos);
        prod = mag_pos * enc_recip;
        hi = (prod >> 24) * full;
        lo = (prod & 64'hFF_FFFF) * full;
        mag = (hi + (lo >> 24)) >> 8;
        if (pos >= 0) begin
            res = mag;
        end else if (enc_recip == 0) begin
            res = 0;
        end else begin
            res = (mag >= full) ? 0 : full - mag;
        end
        if (res > ANGLE_MAX) begin
            res = ANGLE_MAX;
        end
        return res[AngleWidth-1:0];
    endfunction

    function automatic t_result step_encoder(logic a, logic b);
        t_result r;
        bit      rising;
        bit      fwd;
        int      lim;
        rising = !enc_prev_a && a;
        lim = int'(enc_cpr);
        enc_prev_a = a;
        if (rising) begin
            fwd = (a == b) ^ enc_reverse;
            if (fwd) begin
                enc_pos++;
                enc_ticks = enc_ticks + 1;
                if (enc_pos > lim) begin
                    enc_pos = 0;
                    enc_revs = enc_revs + 1;
                end
            end else begin
                enc_pos--;
                enc_ticks = enc_ticks - 1;
                if (enc_pos < -lim) begin
                    enc_pos = 0;
                    enc_revs = enc_revs - 1;
                end
            end
        end
        r = '0;
        r.position    = enc_pos[PosWidth-1:0];
        r.ticks       = enc_ticks;
        r.revolutions = enc_revs;
        r.angle       = wheel_angle(enc_pos);
        r.counted     = rising;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic wait_drained();
        while (expected_results.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] data);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_COUNTS_PER_REV: enc_cpr = data[15:0];
            CFG_REVERSE_DIR:    enc_reverse = data[0];
            CFG_RECIP_COUNTS:   enc_recip = data;
            CFG_ANGLE_UNIT:     enc_radians = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(logic a, logic b, bit typed, t_result want);
        int      gap;
        t_result predicted;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, b, a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = step_encoder(a, b);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // result side
    initial begin
        int      stall;
        t_result got;
        t_result want;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            got = t_result'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", 64'(got), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.position !== want.position)
                    report_mismatch("position", 64'(got.position), 64'(want.position));
                if (got.ticks !== want.ticks)
                    report_mismatch("tick_total", 64'(got.ticks), 64'(want.ticks));
                if (got.revolutions !== want.revolutions)
                    report_mismatch("revolution_total", 64'(got.revolutions),
                                    64'(want.revolutions));
                if (got.angle !== want.angle)
                    report_mismatch("angle", 64'(got.angle), 64'(want.angle));
                if (got.counted !== want.counted)
                    report_mismatch("counted", 64'(got.counted), 64'(want.counted));
            end
        end
    end

    function automatic t_row item_row(logic a, logic b);
        return '{kind: ROW_ITEM, idx: '0, data: '0, a: a, b: b, typed: 1'b0, want: '0};
    endfunction

    function automatic t_row typed_row(logic a, logic b, t_result want);
        return '{kind: ROW_ITEM, idx: '0, data: '0, a: a, b: b, typed: 1'b1, want: want};
    endfunction

    function automatic t_row cfg_row(logic [CfgIdxWidth-1:0] idx, logic [31:0] data);
        return '{kind: ROW_CFG, idx: idx, data: data, a: 1'b0, b: 1'b0, typed: 1'b0,
                 want: '0};
    endfunction

    function automatic logic [31:0] recip_of(logic [15:0] cpr);
        longint unsigned r;
        if (cpr == 0) return 32'hFFFF_FFFF;
        r = (64'd1 << 32) + (cpr / 2);
        r = r / cpr;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    initial begin
        logic [1:0]  gray [4];
        int          phase_idx;
        int          dir;
        int          r;
        logic [15:0] cpr;
        logic [31:0] recip;
        logic        rev_dir;
        logic        unit;
        logic [1:0]  ab;

        gray[0] = 2'b00;
        gray[1] = 2'b10;
        gray[2] = 2'b11;
        gray[3] = 2'b01;

        // after reset: idle, forward, hold, backward through zero
        directed_rows.push_back(typed_row(1'b0, 1'b0, '0));
        directed_rows.push_back(typed_row(1'b1, 1'b1,
            '{pad: '0, counted: 1'b1, angle: 25'd23040, revolutions: '0, ticks: 32'd1,
              position: 17'd1}));
        directed_rows.push_back(typed_row(1'b1, 1'b1,
            '{pad: '0, counted: 1'b0, angle: 25'd23040, revolutions: '0, ticks: 32'd1,
              position: 17'd1}));
        directed_rows.push_back(item_row(1'b0, 1'b1));
        directed_rows.push_back(typed_row(1'b1, 1'b0,
            '{pad: '0, counted: 1'b1, angle: '0, revolutions: '0, ticks: '0,
              position: '0}));
        directed_rows.push_back(item_row(1'b0, 1'b0));
        directed_rows.push_back(typed_row(1'b1, 1'b0,
            '{pad: '0, counted: 1'b1, angle: 25'd23569920, revolutions: '0,
              ticks: 32'hFFFF_FFFF, position: 17'h1FFFF}));
        // zero counts per revolution
        directed_rows.push_back(cfg_row(CFG_COUNTS_PER_REV, 32'd0));
        directed_rows.push_back(item_row(1'b0, 1'b0));
        directed_rows.push_back(item_row(1'b1, 1'b1));
        directed_rows.push_back(item_row(1'b0, 1'b0));
        directed_rows.push_back(item_row(1'b1, 1'b1));
        directed_rows.push_back(item_row(1'b0, 1'b0));
        directed_rows.push_back(item_row(1'b1, 1'b0));
        // swapped direction with a saturating reciprocal
        directed_rows.push_back(cfg_row(CFG_REVERSE_DIR, 32'd1));
        directed_rows.push_back(cfg_row(CFG_RECIP_COUNTS, 32'hFFFF_FFFF));
        directed_rows.push_back(cfg_row(CFG_COUNTS_PER_REV, 32'd3));
        directed_rows.push_back(item_row(1'b0, 1'b1));
        directed_rows.push_back(item_row(1'b1, 1'b0));
        directed_rows.push_back(item_row(1'b0, 1'b1));
        directed_rows.push_back(item_row(1'b1, 1'b0));
        // limit lowered below the current position
        directed_rows.push_back(cfg_row(CFG_COUNTS_PER_REV, 32'd1));
        directed_rows.push_back(item_row(1'b0, 1'b0));
        directed_rows.push_back(item_row(1'b1, 1'b1));
        directed_rows.push_back(item_row(1'b0, 1'b1));
        directed_rows.push_back(item_row(1'b1, 1'b0));
        // radians and a zero reciprocal on a negative position
        directed_rows.push_back(cfg_row(CFG_ANGLE_UNIT, 32'd1));
        directed_rows.push_back(cfg_row(CFG_RECIP_COUNTS, 32'd0));
        directed_rows.push_back(item_row(1'b0, 1'b0));
        directed_rows.push_back(item_row(1'b1, 1'b1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                send_sample(directed_rows[i].a, directed_rows[i].b,
                            directed_rows[i].typed, directed_rows[i].want);
            end
        end

        phase_idx = 0;
        dir = 1;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin cpr = 16'd1;     rev_dir = 1'b0; recip = 32'hFFFF_FFFF; unit = 1'b0; end
                1: begin cpr = 16'hFFFF;  rev_dir = 1'b1; recip = recip_of(16'hFFFF);
                         unit = 1'b1; end
                2: begin cpr = 16'd0;     rev_dir = 1'b0; recip = 32'd0; unit = 1'b0; end
                3: begin
                    cpr = 16'($urandom_range(2, 16));
                    rev_dir = 1'($urandom_range(0, 1));
                    recip = recip_of(cpr);
                    unit = 1'($urandom_range(0, 1));
                end
                4: begin
                    cpr = 16'($urandom_range(1, 40));
                    rev_dir = 1'($urandom_range(0, 1));
                    recip = $urandom();
                    unit = 1'($urandom_range(0, 1));
                end
                default: begin
                    cpr = 16'd4; rev_dir = 1'b1; recip = 32'hFFFF_FFFF; unit = 1'b0;
                end
            endcase
            write_reg(CFG_COUNTS_PER_REV, {16'd0, cpr});
            write_reg(CFG_REVERSE_DIR, {31'd0, rev_dir});
            write_reg(CFG_RECIP_COUNTS, recip);
            write_reg(CFG_ANGLE_UNIT, {31'd0, unit});
            quiet = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == RAND_PHASES - 1 && n == PHASE_ITEMS / 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    ab = 2'($urandom_range(0, 3));
                end else begin
                    if (r >= 15) begin
                        if (r < 18) dir = -dir;
                        phase_idx = (phase_idx + dir) & 3;
                    end
                    ab = gray[phase_idx];
                end
                send_sample(ab[1], ab[0], 1'b0, '0);
            end
            quiet = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/qec_pkg.sv
rtl/qec_count.sv
rtl/qec_angle.sv
rtl/quadrature_encoder_counter_core.sv
tb/tb_quadrature_encoder_counter_core.sv
